// ===== hdl/tcw_pkg.sv =====
// Shared constants, types and helpers for the text console writer.
// No dependencies; the controller, datapath, top level and bench import this package.
package tcw_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 32;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int DEPTH      = MAX_COLS * MAX_ROWS;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  localparam logic [7:0] RST_SCREEN_COLS = 8'd80;
  localparam logic [5:0] RST_SCREEN_ROWS = 6'd25;
  localparam logic [7:0] RST_BLANK_COLOR = 8'h07;
  localparam logic [CELL_W-1:0] RST_BLANK_CELL = {RST_BLANK_COLOR, SPACE_CODE};

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_COLOR = 2'd2;

  localparam logic [0:0] CMD_PUT  = 1'b0;
  localparam logic [0:0] CMD_READ = 1'b1;

  typedef struct packed {
    logic clr;
    logic take;
    logic copy;
    logic drain;
    logic blank;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic copy_last;
    logic blank_last;
    logic scroll_now;
    logic rows_gt1;
    logic out_free;
  } dp_stat_t;

  function automatic logic [7:0] eff_cols(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v == 8'd0) r = 8'd1;
    else if (v > 8'(MAX_COLS)) r = 8'(MAX_COLS);
    return r;
  endfunction

  function automatic logic [5:0] eff_rows(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (v == 6'd0) r = 6'd1;
    else if (v > 6'(MAX_ROWS)) r = 6'(MAX_ROWS);
    return r;
  endfunction

endpackage

// ===== hdl/tcw_ifs.sv =====
// Valid/ready channel interfaces for the text console writer.
// Input word: command and payload; output word: cell and cursor status.
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_code;
  logic [7:0] color;
  logic [6:0] read_col;
  logic [4:0] read_row;

  modport source (output valid, cmd, char_code, color, read_col, read_row, input ready);
  modport sink   (input valid, cmd, char_code, color, read_col, read_row, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_value;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic        scrolled;

  modport source (output valid, cell_value, cursor_col, cursor_row, scrolled, input ready);
  modport sink   (input valid, cell_value, cursor_col, cursor_row, scrolled, output ready);
endinterface

// ===== hdl/text_console_writer_core.sv =====
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ifs, tcw_ctrl, tcw_dp (and tcw_ram below it).
//
//   channel | dir | handshake          | word
//   in_ch   | in  | valid/ready        | cmd, char_code, color, read_col, read_row
//   out_ch  | out | valid/ready        | cell_value, cursor_col, cursor_row, scrolled
//   cfg_*   | in  | cfg_we, no ready   | cfg_index, cfg_data
//
// A put or read word is accepted in IDLE (RAM write or read issue), and the result register
// is then loaded in FINISH, so a new word starts only after the last one is loaded.
// A scroll adds a copy pass over rows 1 to rows-1, a drain state and a blanking pass over
// the last row; a single-row screen skips copy and drain and only blanks.
// After reset a clearing pass fills the screen; no word is accepted then.
// The result load waits while the result register still holds an untaken word;
// no new word is accepted until that load happens.
module text_console_writer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  tcw_in_if.sink                         in_ch,
  tcw_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  tcw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  tcw_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_cmd        (in_ch.cmd),
    .in_char_code  (in_ch.char_code),
    .in_color      (in_ch.color),
    .in_read_col   (in_ch.read_col),
    .in_read_row   (in_ch.read_row),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_cell_value(out_ch.cell_value),
    .out_cursor_col(out_ch.cursor_col),
    .out_cursor_row(out_ch.cursor_row),
    .out_scrolled  (out_ch.scrolled)
  );

endmodule

// ===== hdl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tcw_ctrl.sv =====
// Controller FSM: clear pass, item accept, scroll copy/blank, result hand-off.
// Depends on tcw_pkg (command and status structs).
module tcw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::dp_stat_t  stat,
  output tcw_pkg::dp_cmd_t   cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_COPY   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_BLANK  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.scroll_now) state_nxt = stat.rows_gt1 ? ST_COPY : ST_BLANK;
          else state_nxt = ST_FINISH;
        end
      end
      ST_COPY: begin
        cmd.copy = 1'b1;
        if (stat.copy_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.drain = 1'b1;
        state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        cmd.blank = 1'b1;
        if (stat.blank_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

endmodule

// ===== hdl/tcw_dp.sv =====
// Datapath: config registers, cursor, screen RAM, scan counter, result register.
// Depends on tcw_pkg and tcw_ram.
module tcw_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tcw_pkg::dp_cmd_t                   cmd,
  output tcw_pkg::dp_stat_t                  stat,
  input  logic                               cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_cmd,
  input  logic [7:0]                         in_char_code,
  input  logic [7:0]                         in_color,
  input  logic [tcw_pkg::COL_W-1:0]          in_read_col,
  input  logic [tcw_pkg::ROW_W-1:0]          in_read_row,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tcw_pkg::CELL_W-1:0]         out_cell_value,
  output logic [tcw_pkg::COL_W-1:0]          out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]          out_cursor_row,
  output logic                               out_scrolled
);
  import tcw_pkg::*;

  logic [7:0]        cols_r, cols_nxt;
  logic [5:0]        rows_r, rows_nxt;
  logic [7:0]        blank_r, blank_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [ADDR_W-1:0] scan_r, scan_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic              item_rd_r, item_rd_nxt;
  logic              in_range_r, in_range_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0] out_cell_r, out_cell_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic              out_scr_r, out_scr_nxt;

  logic [7:0]        eff_c, new_c;
  logic [5:0]        eff_r, new_r;
  logic [COL_W-1:0]  eff_c_m1;
  logic [ROW_W-1:0]  eff_r_m1;
  logic [ROW_W-1:0]  scan_row;
  logic [COL_W-1:0]  scan_col;
  logic [7:0]        col_inc;
  logic [5:0]        row_inc;
  logic              is_put, is_nl, line_end, row_over;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign eff_c    = eff_cols(cols_r);
  assign eff_r    = eff_rows(rows_r);
  assign eff_c_m1 = COL_W'(eff_c - 8'd1);
  assign eff_r_m1 = ROW_W'(eff_r - 6'd1);
  assign scan_row = scan_r[ADDR_W-1:COL_W];
  assign scan_col = scan_r[COL_W-1:0];
  assign col_inc  = {1'b0, cur_col_r} + 8'd1;
  assign row_inc  = {1'b0, cur_row_r} + 6'd1;
  assign is_put   = (in_cmd == CMD_PUT);
  assign is_nl    = (in_char_code == NEWLINE_CODE);
  assign line_end = is_nl || (col_inc >= eff_c);
  assign row_over = (row_inc >= eff_r);

  assign stat.clr_last   = &scan_r;
  assign stat.copy_last  = (scan_row == eff_r_m1) && (scan_col == eff_c_m1);
  assign stat.blank_last = (scan_col == eff_c_m1);
  assign stat.scroll_now = is_put && line_end && row_over;
  assign stat.rows_gt1   = (eff_r != 6'd1);
  assign stat.out_free   = !out_valid_r || out_ready;

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = scan_r;
    if (cmd.clr) begin
      ram_we    = 1'b1;
      ram_waddr = scan_r;
      ram_wdata = RST_BLANK_CELL;
    end else if (cmd.take) begin
      if (is_put) begin
        ram_we    = !is_nl;
        ram_waddr = {cur_row_r, cur_col_r};
        ram_wdata = {in_color, in_char_code};
      end else begin
        ram_re    = 1'b1;
        ram_raddr = {in_read_row, in_read_col};
      end
    end else if (cmd.copy) begin
      ram_we = pend_v_r;
      ram_re = 1'b1;
    end else if (cmd.drain) begin
      ram_we = 1'b1;
    end else if (cmd.blank) begin
      ram_we    = 1'b1;
      ram_waddr = {eff_r_m1, scan_col};
      ram_wdata = {blank_r, SPACE_CODE};
    end
  end

  always_comb begin
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    blank_nxt     = blank_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    scan_nxt      = scan_r;
    pend_addr_nxt = pend_addr_r;
    pend_v_nxt    = pend_v_r;
    item_rd_nxt   = item_rd_r;
    in_range_nxt  = in_range_r;
    scrolled_nxt  = scrolled_r;
    new_c         = eff_c;
    new_r         = eff_r;

    if (cmd.clr) scan_nxt = scan_r + ADDR_W'(1);

    if (cmd.take) begin
      item_rd_nxt  = !is_put;
      in_range_nxt = ({1'b0, in_read_col} < eff_c) && ({1'b0, in_read_row} < eff_r);
      scrolled_nxt = stat.scroll_now;
      pend_v_nxt   = 1'b0;
      scan_nxt     = {ROW_W'(1), COL_W'(0)};
      if (is_put) begin
        if (line_end) begin
          cur_col_nxt = '0;
          cur_row_nxt = row_over ? eff_r_m1 : row_inc[ROW_W-1:0];
        end else begin
          cur_col_nxt = col_inc[COL_W-1:0];
        end
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_SCREEN_COLS) begin
        cols_nxt = cfg_data;
        new_c    = eff_cols(cfg_data);
      end else if (cfg_index == CFG_SCREEN_ROWS) begin
        rows_nxt = cfg_data[5:0];
        new_r    = eff_rows(cfg_data[5:0]);
      end else if (cfg_index == CFG_BLANK_COLOR) begin
        blank_nxt = cfg_data;
      end
      if ({1'b0, cur_col_r} >= new_c) cur_col_nxt = COL_W'(new_c - 8'd1);
      if ({1'b0, cur_row_r} >= new_r) cur_row_nxt = ROW_W'(new_r - 6'd1);
    end

    if (cmd.copy) begin
      pend_addr_nxt = {scan_row - ROW_W'(1), scan_col};
      pend_v_nxt    = 1'b1;
      if (scan_col == eff_c_m1) scan_nxt = {scan_row + ROW_W'(1), COL_W'(0)};
      else scan_nxt = {scan_row, scan_col + COL_W'(1)};
    end

    if (cmd.blank) scan_nxt = {scan_row, scan_col + COL_W'(1)};
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cell_nxt  = out_cell_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_scr_nxt   = out_scr_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
      out_cell_nxt  = (item_rd_r && in_range_r) ? ram_rdata : '0;
      out_col_nxt   = cur_col_r;
      out_row_nxt   = cur_row_r;
      out_scr_nxt   = scrolled_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= RST_SCREEN_COLS;
      rows_r      <= RST_SCREEN_ROWS;
      blank_r     <= RST_BLANK_COLOR;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      scan_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      blank_r     <= blank_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      scan_r      <= scan_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    item_rd_r   <= item_rd_nxt;
    in_range_r  <= in_range_nxt;
    scrolled_r  <= scrolled_nxt;
    out_cell_r  <= out_cell_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_scr_r   <= out_scr_nxt;
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_scrolled   = out_scr_r;

endmodule

// ===== hdl/tcw_checker.sv =====
// Port-level assertions for the text console writer, bound to the top level.
// Depends on text_console_writer_core ports only.
module tcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_cell_value,
  input logic [6:0]  out_cursor_col,
  input logic        out_scrolled
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_value))
    else $error("output word dropped or changed while stalled");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("input accepted during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in flight");

  a_scroll_put: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cell_value == 16'd0)
    else $error("scrolled word carries cell data");

  a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cursor_col == 7'd0)
    else $error("cursor not at column 0 after scroll");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_cell_value(out_ch.cell_value),
  .out_cursor_col(out_ch.cursor_col),
  .out_scrolled  (out_ch.scrolled)
);

// ===== sim/testbench.sv =====
// Self-checking bench for text_console_writer_core: a directed table, then random phases.
// Needs tcw_pkg, tcw_ifs and the core RTL; results are checked against an in-bench screen model.
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES = 20;
  localparam int PHASE_WORDS = 65;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [6:0] read_col;
    logic [4:0] read_row;
  } console_word_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } console_res_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           data;
    console_word_t        w;
    bit                   typed;
    console_res_t         res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();

  text_console_writer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // screen model
  logic [15:0] screen_cells [0:DEPTH-1];
  logic [7:0]  scr_cols;
  logic [5:0]  scr_rows;
  logic [7:0]  scr_blank;
  int          cur_c;
  int          cur_r;

  console_res_t pending_status [$];
  plan_row_t    plan [$];
  logic         typed_check;
  console_res_t typed_status;
  int           words_sent;
  int           results_seen;
  int           errors;
  int           idle_cycles;
  int           send_idle_pct;
  int           recv_stall_pct;

  function automatic int used_cols();
    if (scr_cols == 8'd0) return 1;
    if (int'(scr_cols) > MAX_COLS) return MAX_COLS;
    return int'(scr_cols);
  endfunction

  function automatic int used_rows();
    if (scr_rows == 6'd0) return 1;
    if (int'(scr_rows) > MAX_ROWS) return MAX_ROWS;
    return int'(scr_rows);
  endfunction

  function automatic void clamp_cursor();
    if (cur_c >= used_cols()) cur_c = used_cols() - 1;
    if (cur_r >= used_rows()) cur_r = used_rows() - 1;
  endfunction

  // newline; scrolls the used area when the last row is passed
  function automatic logic advance_row();
    int nc, nr, r, c;
    nc = used_cols();
    nr = used_rows();
    cur_c = 0;
    cur_r = cur_r + 1;
    if (cur_r < nr) return 1'b0;
    cur_r = nr - 1;
    for (r = 1; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        screen_cells[(r - 1) * MAX_COLS + c] = screen_cells[r * MAX_COLS + c];
      end
    end
    for (c = 0; c < nc; c++) begin
      screen_cells[(nr - 1) * MAX_COLS + c] = {scr_blank, SPACE_CODE};
    end
    return 1'b1;
  endfunction

  function automatic console_res_t console_result(console_word_t w);
    console_res_t r;
    r = '0;
    clamp_cursor();
    if (w.cmd == CMD_READ) begin
      if (int'(w.read_col) < used_cols() && int'(w.read_row) < used_rows()) begin
        r.cell_value = screen_cells[int'(w.read_row) * MAX_COLS + int'(w.read_col)];
      end
    end else if (w.char_code == NEWLINE_CODE) begin
      r.scrolled = advance_row();
    end else begin
      screen_cells[cur_r * MAX_COLS + cur_c] = {w.color, w.char_code};
      cur_c = cur_c + 1;
      if (cur_c >= used_cols()) r.scrolled = advance_row();
    end
    r.cursor_col = 7'(cur_c);
    r.cursor_row = 5'(cur_r);
    return r;
  endfunction

  task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
    plan_row_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.data = 8'(data);
    plan.push_back(p);
  endtask

  task automatic plan_word(input logic cmd, input int ch, input int color, input int rcol,
                           input int rrow, input bit typed, input int cell_v, input int col,
                           input int row, input int scr);
    plan_row_t p;
    p = '{default: '0};
    p.w = {cmd, 8'(ch), 8'(color), 7'(rcol), 5'(rrow)};
    p.typed = typed;
    p.res = {16'(cell_v), 7'(col), 5'(row), 1'(scr)};
    plan.push_back(p);
  endtask

  task automatic send_word(input console_word_t w, input bit typed, input console_res_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= w.cmd;
    in_ch.char_code <= w.char_code;
    in_ch.color     <= w.color;
    in_ch.read_col  <= w.read_col;
    in_ch.read_row  <= w.read_row;
    typed_check     <= typed;
    typed_status    <= res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (results_seen < words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_SCREEN_COLS: begin
        scr_cols = data;
        clamp_cursor();
      end
      CFG_SCREEN_ROWS: begin
        scr_rows = data[5:0];
        clamp_cursor();
      end
      CFG_BLANK_COLOR: scr_blank = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
    end
  endtask

  // receiver
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // accept side prediction, result checking, watchdog
  always @(posedge clk) begin
    console_res_t predicted;
    console_res_t want;
    if (in_ch.valid && in_ch.ready) begin
      predicted = console_result({in_ch.cmd, in_ch.char_code, in_ch.color,
                                  in_ch.read_col, in_ch.read_row});
      pending_status.push_back(typed_check ? typed_status : predicted);
    end
    if (out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got cell 0x%0h cursor %0d,%0d scrolled %0b",
                 $time, out_ch.cell_value, out_ch.cursor_col, out_ch.cursor_row,
                 out_ch.scrolled);
      end else begin
        want = pending_status.pop_front();
        check_field("cell_value", want.cell_value, out_ch.cell_value);
        check_field("cursor_col", 16'(want.cursor_col), 16'(out_ch.cursor_col));
        check_field("cursor_row", 16'(want.cursor_row), 16'(out_ch.cursor_row));
        check_field("scrolled", 16'(want.scrolled), 16'(out_ch.scrolled));
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    console_word_t w;
    plan_row_t     pr;
    int            ph;
    int            read_pct;
    int            nl_pct;
    logic [7:0]    cols_v;
    logic [5:0]    rows_v;

    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_PUT;
    in_ch.char_code = '0;
    in_ch.color     = '0;
    in_ch.read_col  = '0;
    in_ch.read_row  = '0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SCREEN_COLS;
    cfg_data        = '0;
    typed_check     = 1'b0;
    typed_status    = '0;
    words_sent      = 0;
    results_seen    = 0;
    errors          = 0;
    idle_cycles     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;

    scr_cols  = RST_SCREEN_COLS;
    scr_rows  = RST_SCREEN_ROWS;
    scr_blank = RST_BLANK_COLOR;
    cur_c     = 0;
    cur_r     = 0;
    foreach (screen_cells[i]) screen_cells[i] = RST_BLANK_CELL;

    //        cmd       char          color  rcol rrow typed cell      col row scr
    plan_word(CMD_READ, 8'h00,        8'h00, 0,   0,   1,    16'h0720, 0,  0,  0);
    plan_word(CMD_READ, 8'hFF,        8'hFF, 127, 31,  1,    16'h0000, 0,  0,  0);
    plan_word(CMD_READ, 8'h00,        8'h00, 79,  24,  1,    16'h0720, 0,  0,  0);
    plan_word(CMD_READ, 8'h00,        8'h00, 80,  0,   1,    16'h0000, 0,  0,  0);
    plan_word(CMD_PUT,  8'h41,        8'hFF, 0,   0,   1,    16'h0000, 1,  0,  0);
    plan_word(CMD_PUT,  8'h00,        8'h00, 127, 31,  1,    16'h0000, 2,  0,  0);
    plan_word(CMD_PUT,  8'hFF,        8'h1E, 0,   0,   1,    16'h0000, 3,  0,  0);
    plan_word(CMD_READ, NEWLINE_CODE, 8'h00, 0,   0,   1,    16'hFF41, 3,  0,  0);
    plan_word(CMD_PUT,  NEWLINE_CODE, 8'h55, 0,   0,   1,    16'h0000, 0,  1,  0);
    plan_word(CMD_READ, 8'h00,        8'h00, 2,   0,   1,    16'h1EFF, 0,  1,  0);
    // 3x2 screen: wrap off the last row scrolls
    plan_cfg(CFG_BLANK_COLOR, 8'hFF);
    plan_cfg(CFG_SCREEN_COLS, 3);
    plan_cfg(CFG_SCREEN_ROWS, 2);
    plan_word(CMD_PUT,  8'h78,        8'h12, 0,   0,   0,    0,        0,  0,  0);
    plan_word(CMD_PUT,  8'h79,        8'h34, 0,   0,   0,    0,        0,  0,  0);
    plan_word(CMD_PUT,  8'h7A,        8'h56, 0,   0,   1,    16'h0000, 0,  1,  1);
    plan_word(CMD_READ, 8'h00,        8'h00, 0,   1,   1,    16'hFF20, 0,  1,  0);
    plan_word(CMD_READ, 8'h00,        8'h00, 2,   0,   0,    0,        0,  0,  0);
    plan_word(CMD_PUT,  NEWLINE_CODE, 8'h00, 0,   0,   1,    16'h0000, 0,  1,  1);
    // zero sizes clamp to a single cell
    plan_cfg(CFG_SCREEN_COLS, 0);
    plan_cfg(CFG_SCREEN_ROWS, 0);
    plan_word(CMD_PUT,  8'h71,        8'h9A, 0,   0,   1,    16'h0000, 0,  0,  1);
    plan_word(CMD_READ, 8'h00,        8'h00, 0,   0,   1,    16'hFF20, 0,  0,  0);
    plan_word(CMD_READ, 8'h00,        8'h00, 1,   0,   1,    16'h0000, 0,  0,  0);
    // oversize values clamp to the maximum; spare index is a no-op
    plan_cfg(CFG_SPARE, 8'hAB);
    plan_cfg(CFG_SCREEN_COLS, 255);
    plan_cfg(CFG_SCREEN_ROWS, 63);
    plan_cfg(CFG_BLANK_COLOR, 8'h00);
    plan_word(CMD_READ, 8'h00,        8'h00, 127, 31,  1,    16'h0720, 0,  0,  0);
    plan_word(CMD_READ, 8'h00,        8'h00, 3,   0,   0,    0,        0,  0,  0);
    plan_word(CMD_PUT,  8'h7F,        8'h80, 0,   0,   0,    0,        0,  0,  0);
    plan_word(CMD_PUT,  NEWLINE_CODE, 8'hAA, 0,   0,   0,    0,        0,  0,  0);
    plan_word(CMD_PUT,  8'h77,        8'h01, 0,   0,   0,    0,        0,  0,  0);
    // shrink under the cursor
    plan_cfg(CFG_SCREEN_COLS, 1);
    plan_cfg(CFG_SCREEN_ROWS, 1);
    plan_word(CMD_READ, 8'h00,        8'h00, 0,   0,   0,    0,        0,  0,  0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (plan.size() > 0) begin
      pr = plan.pop_front();
      if (pr.is_cfg) begin
        wait_drained();
        write_reg(pr.idx, pr.data);
      end else begin
        send_word(pr.w, pr.typed, pr.res);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 53;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 53;
        end
        default: begin
          send_idle_pct  = 25;
          recv_stall_pct = 25;
        end
      endcase
      // two phases at full size, newline heavy, to scroll the whole store
      if (ph == 5 || ph == 13) begin
        cols_v = (ph == 5) ? 8'd255 : 8'd128;
        rows_v = (ph == 5) ? 6'd63 : 6'd32;
      end else begin
        if ($urandom_range(9) < 7) begin
          cols_v = 8'($urandom_range(1, 24));
        end else begin
          case ($urandom_range(3))
            0: cols_v = 8'd0;
            1: cols_v = 8'd128;
            2: cols_v = 8'd255;
            default: cols_v = 8'($urandom_range(25, 254));
          endcase
        end
        if ($urandom_range(9) < 7) begin
          rows_v = 6'($urandom_range(1, 8));
        end else begin
          case ($urandom_range(3))
            0: rows_v = 6'd0;
            1: rows_v = 6'd32;
            2: rows_v = 6'd63;
            default: rows_v = 6'($urandom_range(9, 62));
          endcase
        end
      end
      write_reg(CFG_SCREEN_COLS, cols_v);
      write_reg(CFG_SCREEN_ROWS, {2'b00, rows_v});
      write_reg(CFG_BLANK_COLOR, 8'($urandom_range(255)));
      if (ph == 5 || ph == 13) begin
        read_pct = 10;
        nl_pct   = 90;
      end else begin
        read_pct = $urandom_range(10, 50);
        case ($urandom_range(2))
          0: nl_pct = 3;
          1: nl_pct = 15;
          default: nl_pct = 40;
        endcase
        // keep scrolls rare on big screens
        if (used_cols() * used_rows() > 512) nl_pct = 2;
      end
      repeat (PHASE_WORDS) begin
        w.cmd       = ($urandom_range(99) < read_pct) ? CMD_READ : CMD_PUT;
        w.char_code = ($urandom_range(99) < nl_pct) ? NEWLINE_CODE : 8'($urandom_range(255));
        w.color     = 8'($urandom_range(255));
        if ($urandom_range(1) == 0) begin
          w.read_col = 7'($urandom_range(used_cols() - 1));
          w.read_row = 5'($urandom_range(used_rows() - 1));
        end else begin
          w.read_col = 7'($urandom);
          w.read_row = 5'($urandom);
        end
        send_word(w, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
